// File: design/string_key_hash_table_defines.svh
// Assertion macros for the string key hash table.
// Used by the top level only; no other dependencies.
`ifndef STRING_KEY_HASH_TABLE_DEFINES_SVH
`define STRING_KEY_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SKHT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("skht assertion failed");

// Next-cycle implication, disabled in reset.
`define SKHT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("skht assertion failed");

`endif

// File: design/skht_pkg.sv
// Shared types and constants for the string key hash table.
// No dependencies.
package skht_pkg;

  localparam int TABLE_DEPTH  = 64;
  localparam int MAX_NAME_LEN = 16;
  localparam int HANDLER_BITS = 16;

  localparam int SLOT_W   = $clog2(TABLE_DEPTH);
  localparam int SIZE_W   = 7;
  localparam int LEN_W    = $clog2(MAX_NAME_LEN + 2);
  localparam int BIDX_W   = $clog2(MAX_NAME_LEN);
  localparam int HASH_W   = 64;
  localparam int DIV_BITS = 4;
  localparam int MOD_CYCLES = HASH_W / DIV_BITS;
  localparam int MODC_W   = $clog2(MOD_CYCLES);
  localparam int ROW_W    = MAX_NAME_LEN * 8 + LEN_W + HANDLER_BITS;

  localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd61;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_FOUND      = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_DUPLICATE  = 3'd3,
    ST_FULL       = 3'd4,
    ST_TOO_LONG   = 3'd5,
    ST_NO_HANDLER = 3'd6
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_MOD       = 5'b00010,
    S_PROBE_RD  = 5'b00100,
    S_PROBE_CMP = 5'b01000,
    S_EMIT      = 5'b10000
  } state_t;

endpackage

// File: design/skht_req_if.sv
// Request channel: one name character per request.
// Depends on skht_pkg.
interface skht_req_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [7:0]                        name_char;
  logic                              name_last;
  logic [skht_pkg::HANDLER_BITS-1:0] handler_id;

  modport source(output valid, output op, output name_char, output name_last,
                 output handler_id, input ready);
  modport sink(input valid, input op, input name_char, input name_last,
               input handler_id, output ready);
endinterface

// File: design/skht_rsp_if.sv
// Response channel: one result per completed name.
// Depends on skht_pkg.
interface skht_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        status;
  logic [skht_pkg::SLOT_W-1:0]       slot;
  logic [skht_pkg::HANDLER_BITS-1:0] found_handler;

  modport source(output valid, output status, output slot, output found_handler,
                 input ready);
  modport sink(input valid, input status, input slot, input found_handler,
               output ready);
endinterface

// File: design/skht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: design/string_key_hash_table.sv
// Top level of the string key hash table.
// Depends on skht_pkg, skht_req_if, skht_rsp_if, skht_ram and the defines header.
//
// Usage: names arrive on req one character per request; name_last marks the
// final character, and op and handler_id are taken from that request. Every
// completed name gives one response on rsp (status, slot, found_handler).
// table_size is written through cfg_we / cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Characters are taken one per cycle, but only while the block is idle. After
// the last character the 64-bit hash is reduced modulo the table size four
// bits a cycle. Each stored slot that is compared takes a probe read (valid
// check and address), then a compare of the registered entry row; an empty
// slot, or the end of the probe after table_size slots, leads straight to
// S_EMIT, which loads the response register. A name error (no handler, too
// long) still goes through the reduction stage. The entry memory has one
// read port, which sets the probe rate. Reset clears the valid bits of all
// slots at once and restores table_size to 61; no clearing pass is needed.
// A stalled receiver holds the response register; new characters are still
// accepted, and the next response waits.
`include "string_key_hash_table_defines.svh"

module string_key_hash_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [skht_pkg::SIZE_W-1:0] cfg_wdata,
  skht_req_if.sink                  req,
  skht_rsp_if.source                rsp
);
  localparam int NB = skht_pkg::MAX_NAME_LEN;

  skht_pkg::state_t state, state_next;

  logic [skht_pkg::SIZE_W-1:0]       table_size;
  logic [skht_pkg::SIZE_W-1:0]       ts_eff;
  logic [skht_pkg::SIZE_W-1:0]       ts_r;
  logic [skht_pkg::HASH_W-1:0]       hash, hash_next, sext;
  logic [skht_pkg::LEN_W-1:0]        len, len_next, len_fin;
  logic [NB-1:0][7:0]                name_buf;
  logic                              op_r;
  logic [skht_pkg::HANDLER_BITS-1:0] hid_r;
  logic [skht_pkg::HASH_W-1:0]       dq;
  logic [skht_pkg::SIZE_W-1:0]       rem, rem_next;
  logic [skht_pkg::MODC_W-1:0]       mod_cnt;
  logic [skht_pkg::SLOT_W-1:0]       idx;
  logic [skht_pkg::SIZE_W-1:0]       visited;
  logic [skht_pkg::SIZE_W-1:0]       idx_inc;
  logic [skht_pkg::TABLE_DEPTH-1:0]  valid;
  logic                              req_fire, last_fire;

  logic                              ram_we, ram_re;
  logic [skht_pkg::ROW_W-1:0]        ram_wdata, ram_rdata;
  logic [NB-1:0][7:0]                row_chars;
  logic [skht_pkg::LEN_W-1:0]        row_len;
  logic [skht_pkg::HANDLER_BITS-1:0] row_hid;
  logic                              row_match;

  skht_pkg::status_t                 res_status;
  logic [skht_pkg::SLOT_W-1:0]       res_slot;
  logic [skht_pkg::HANDLER_BITS-1:0] res_hid;
  logic                              rsp_valid;
  logic                              rsp_free;

  assign req.ready = (state == skht_pkg::S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign last_fire = req_fire && req.name_last;
  assign rsp_free  = !rsp_valid || rsp.ready;

  // Clamp the configured size into 1 .. TABLE_DEPTH.
  always_comb begin
    ts_eff = table_size;
    if (table_size == '0) begin
      ts_eff = skht_pkg::SIZE_W'(1);
    end else if (table_size > skht_pkg::SIZE_W'(skht_pkg::TABLE_DEPTH)) begin
      ts_eff = skht_pkg::SIZE_W'(skht_pkg::TABLE_DEPTH);
    end
  end

  assign sext      = {{(skht_pkg::HASH_W-8){req.name_char[7]}}, req.name_char};
  assign hash_next = (hash << 5) + hash + sext;
  assign len_next  = (len <= skht_pkg::LEN_W'(NB)) ? len + 1'b1 : len;

  // Four restoring remainder steps per cycle.
  always_comb begin
    logic [skht_pkg::SIZE_W-1:0] r;
    r = rem;
    for (int k = 0; k < skht_pkg::DIV_BITS; k++) begin
      r = {r[skht_pkg::SIZE_W-2:0], dq[skht_pkg::HASH_W-1-k]};
      if (r >= ts_r) begin
        r = r - ts_r;
      end
    end
    rem_next = r;
  end

  assign idx_inc = skht_pkg::SIZE_W'(idx) + 1'b1;

  assign row_hid   = ram_rdata[skht_pkg::HANDLER_BITS-1:0];
  assign row_len   = ram_rdata[skht_pkg::HANDLER_BITS +: skht_pkg::LEN_W];
  assign row_chars = ram_rdata[skht_pkg::ROW_W-1 -: NB*8];

  // Compare only the bytes inside the name length.
  always_comb begin
    row_match = (row_len == len_fin);
    for (int i = 0; i < NB; i++) begin
      if ((skht_pkg::LEN_W'(i) < len_fin) && (row_chars[i] != name_buf[i])) begin
        row_match = 1'b0;
      end
    end
  end

  assign ram_wdata = {name_buf, len_fin, hid_r};
  assign ram_we = (state == skht_pkg::S_PROBE_RD) && (visited != ts_r) && !valid[idx]
                  && (op_r == skht_pkg::OP_INSERT);
  assign ram_re = (state == skht_pkg::S_PROBE_RD) && (visited != ts_r) && valid[idx];

  skht_ram #(
    .WIDTH(skht_pkg::ROW_W),
    .DEPTH(skht_pkg::TABLE_DEPTH)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      skht_pkg::S_IDLE: begin
        if (last_fire) begin
          state_next = skht_pkg::S_MOD;
        end
      end
      skht_pkg::S_MOD: begin
        if (mod_cnt == skht_pkg::MODC_W'(skht_pkg::MOD_CYCLES - 1)) begin
          if ((op_r == skht_pkg::OP_INSERT && hid_r == '0) ||
              (len_fin > skht_pkg::LEN_W'(NB))) begin
            state_next = skht_pkg::S_EMIT;
          end else begin
            state_next = skht_pkg::S_PROBE_RD;
          end
        end
      end
      skht_pkg::S_PROBE_RD: begin
        if (ram_re) begin
          state_next = skht_pkg::S_PROBE_CMP;
        end else begin
          state_next = skht_pkg::S_EMIT;
        end
      end
      skht_pkg::S_PROBE_CMP: begin
        state_next = row_match ? skht_pkg::S_EMIT : skht_pkg::S_PROBE_RD;
      end
      skht_pkg::S_EMIT: begin
        if (rsp_free) begin
          state_next = skht_pkg::S_IDLE;
        end
      end
      default: state_next = skht_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= skht_pkg::S_IDLE;
      table_size <= skht_pkg::SIZE_RESET;
      hash       <= skht_pkg::HASH_SEED;
      len        <= '0;
      valid      <= '0;
      rsp_valid  <= 1'b0;
      mod_cnt    <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        table_size <= cfg_wdata;
      end
      if (req_fire) begin
        hash <= req.name_last ? skht_pkg::HASH_SEED : hash_next;
        len  <= req.name_last ? '0 : len_next;
      end
      if (state == skht_pkg::S_MOD) begin
        mod_cnt <= mod_cnt + 1'b1;
      end else begin
        mod_cnt <= '0;
      end
      if (ram_we) begin
        valid[idx] <= 1'b1;
      end
      if (state == skht_pkg::S_EMIT && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset.
  always_ff @(posedge clk) begin
    if (req_fire && (len < skht_pkg::LEN_W'(NB))) begin
      name_buf[len[skht_pkg::BIDX_W-1:0]] <= req.name_char;
    end
    if (last_fire) begin
      dq      <= hash_next;
      len_fin <= len_next;
      op_r    <= req.op;
      hid_r   <= req.handler_id;
      ts_r    <= ts_eff;
      rem     <= '0;
    end
    if (state == skht_pkg::S_MOD) begin
      dq  <= dq << skht_pkg::DIV_BITS;
      rem <= rem_next;
      if (mod_cnt == skht_pkg::MODC_W'(skht_pkg::MOD_CYCLES - 1)) begin
        idx     <= rem_next[skht_pkg::SLOT_W-1:0];
        visited <= '0;
        if (op_r == skht_pkg::OP_INSERT && hid_r == '0) begin
          res_status <= skht_pkg::ST_NO_HANDLER;
        end else begin
          res_status <= skht_pkg::ST_TOO_LONG;
        end
        res_slot <= '0;
        res_hid  <= '0;
      end
    end
    if (state == skht_pkg::S_PROBE_RD && !ram_re) begin
      if (visited == ts_r) begin
        res_status <= (op_r == skht_pkg::OP_INSERT) ? skht_pkg::ST_FULL
                                                    : skht_pkg::ST_NOT_FOUND;
        res_slot   <= '0;
      end else if (op_r == skht_pkg::OP_INSERT) begin
        res_status <= skht_pkg::ST_INSERTED;
        res_slot   <= idx;
      end else begin
        res_status <= skht_pkg::ST_NOT_FOUND;
        res_slot   <= '0;
      end
      res_hid <= '0;
    end
    if (state == skht_pkg::S_PROBE_CMP) begin
      if (row_match) begin
        res_status <= (op_r == skht_pkg::OP_INSERT) ? skht_pkg::ST_DUPLICATE
                                                    : skht_pkg::ST_FOUND;
        res_slot   <= idx;
        res_hid    <= row_hid;
      end else begin
        // advance with wrap at the table size
        visited <= visited + 1'b1;
        idx     <= (idx_inc == ts_r) ? '0 : idx_inc[skht_pkg::SLOT_W-1:0];
      end
    end
    if (state == skht_pkg::S_EMIT && rsp_free) begin
      rsp.status        <= res_status;
      rsp.slot          <= res_slot;
      rsp.found_handler <= res_hid;
    end
  end

  assign rsp.valid = rsp_valid;

  `SKHT_ASSERT_IMP(a_idx_in_range, clk, rst, state == skht_pkg::S_PROBE_RD, skht_pkg::SIZE_W'(idx) < ts_r)
  `SKHT_ASSERT_IMP(a_visit_bound, clk, rst, state == skht_pkg::S_PROBE_RD, visited <= ts_r)
  `SKHT_ASSERT_NXT(a_write_ends, clk, rst, ram_we, state == skht_pkg::S_EMIT)
  `SKHT_ASSERT_NXT(a_read_cmp, clk, rst, ram_re, state == skht_pkg::S_PROBE_CMP)

endmodule

// File: sim/string_key_hash_table_checker.sv
// Checker for the string key hash table: tracks accepted requests, predicts
// each response and compares it. Depends on skht_pkg and the channel interfaces.
module string_key_hash_table_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [skht_pkg::SIZE_W-1:0] cfg_wdata,
  skht_req_if req,
  skht_rsp_if rsp,
  output int fail_count,
  output int rsp_pending,
  output int rsp_total
);
  import skht_pkg::*;

  typedef struct packed {
    status_t status;
    logic [SLOT_W-1:0] slot;
    logic [HANDLER_BITS-1:0] handler;
  } lookup_rsp_t;

  lookup_rsp_t expected_rsps[$];

  logic [SIZE_W-1:0] size_reg;
  logic [HASH_W-1:0] name_hash;
  logic [7:0] name_buf [MAX_NAME_LEN];
  int name_len;
  logic slot_used [TABLE_DEPTH];
  logic [7:0] slot_chars [TABLE_DEPTH][MAX_NAME_LEN];
  int slot_len [TABLE_DEPTH];
  logic [HANDLER_BITS-1:0] slot_handler [TABLE_DEPTH];

  assign rsp_pending = expected_rsps.size();

  function automatic bit name_stored_at(int s);
    if (slot_len[s] != name_len) return 0;
    for (int k = 0; k < name_len; k++)
      if (slot_chars[s][k] != name_buf[k]) return 0;
    return 1;
  endfunction

  // Fold one request into the name and, on the last character, run the op.
  task automatic hash_and_resolve(logic op, logic [7:0] ch, logic last,
                                  logic [HANDLER_BITS-1:0] hid);
    lookup_rsp_t r;
    int sz, idx, n;
    bit hit, empty;
    name_hash = (name_hash << 5) + name_hash + {{56{ch[7]}}, ch};
    if (name_len < MAX_NAME_LEN) name_buf[name_len] = ch;
    if (name_len <= MAX_NAME_LEN) name_len++;
    if (!last) return;
    r = '{ST_INSERTED, '0, '0};
    hit = 0;
    empty = 0;
    if (op == OP_INSERT && hid == 0) begin
      r.status = ST_NO_HANDLER;
    end else if (name_len > MAX_NAME_LEN) begin
      r.status = ST_TOO_LONG;
    end else begin
      sz = (size_reg == 0) ? 1 : (size_reg > TABLE_DEPTH) ? TABLE_DEPTH : size_reg;
      idx = name_hash % sz;
      for (n = 0; n < sz; n++) begin
        if (!slot_used[idx]) begin
          empty = 1;
          break;
        end
        if (name_stored_at(idx)) begin
          hit = 1;
          break;
        end
        idx = (idx + 1 == sz) ? 0 : idx + 1;
      end
      if (hit) begin
        r.status = (op == OP_INSERT) ? ST_DUPLICATE : ST_FOUND;
        r.slot = idx;
        r.handler = slot_handler[idx];
      end else if (op == OP_LOOKUP) begin
        r.status = ST_NOT_FOUND;
      end else if (empty) begin
        slot_used[idx] = 1;
        slot_len[idx] = name_len;
        for (int k = 0; k < name_len; k++) slot_chars[idx][k] = name_buf[k];
        slot_handler[idx] = hid;
        r.slot = idx;
      end else begin
        r.status = ST_FULL;
      end
    end
    expected_rsps.push_back(r);
    name_hash = HASH_SEED;
    name_len = 0;
  endtask

  always @(posedge clk) begin
    lookup_rsp_t e;
    if (rst) begin
      size_reg = SIZE_RESET;
      name_hash = HASH_SEED;
      name_len = 0;
      for (int s = 0; s < TABLE_DEPTH; s++) slot_used[s] = 0;
      expected_rsps.delete();
      fail_count = 0;
      rsp_total = 0;
    end else begin
      if (cfg_we) size_reg = cfg_wdata;
      if (rsp.valid && rsp.ready) begin
        rsp_total++;
        if (expected_rsps.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected response status=%0d slot=%0d handler=%0d",
                     rsp.status, rsp.slot, rsp.found_handler);
        end else begin
          e = expected_rsps.pop_front();
          if (rsp.status !== e.status || rsp.slot !== e.slot ||
              rsp.found_handler !== e.handler) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                       e.status, e.slot, e.handler,
                       rsp.status, rsp.slot, rsp.found_handler);
          end
        end
      end
      if (req.valid && req.ready)
        hash_and_resolve(req.op, req.name_char, req.name_last, req.handler_id);
    end
  end
endmodule

// File: sim/tb_string_key_hash_table.sv
// Testbench top for the string key hash table: drives names and table sizes,
// gives the verdict. Depends on skht_pkg, the interfaces and the checker.
module tb_string_key_hash_table;
  import skht_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [SIZE_W-1:0] cfg_wdata = '0;
  int fail_count, rsp_pending, rsp_total;
  int idle_cycles = 0;
  int req_total = 0;
  bit calm = 0;
  bit timed_out = 0;

  // Small pool of names so lookups and duplicates hit often.
  logic [7:0] pool_chars [32][MAX_NAME_LEN + 2];
  int pool_len [32];

  skht_req_if req();
  skht_rsp_if rsp();

  always #1 clk = ~clk;

  string_key_hash_table i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req.sink), .rsp(rsp.source)
  );

  string_key_hash_table_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req), .rsp(rsp), .fail_count(fail_count),
    .rsp_pending(rsp_pending), .rsp_total(rsp_total)
  );

  initial begin
    req.valid = 0;
    req.op = 0;
    req.name_char = 0;
    req.name_last = 0;
    req.handler_id = 0;
    rsp.ready = 0;
  end

  // Receiver drops ready in random stall bursts; ready stays high in reset and when calm.
  always @(posedge clk) begin
    int stall;
    if (rst || calm) begin
      rsp.ready <= 1;
    end else if (stall > 0) begin
      stall--;
      rsp.ready <= 0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall = $urandom_range(0, 3);
      rsp.ready <= 0;
    end else begin
      rsp.ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("watchdog expired");
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_char(logic op, logic [7:0] ch, logic last, logic [15:0] hid);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req.valid <= 1;
    req.op <= op;
    req.name_char <= ch;
    req.name_last <= last;
    req.handler_id <= hid;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    req_total++;
  endtask

  task automatic send_name(logic op, int len, logic [7:0] c [], logic [15:0] hid);
    for (int k = 0; k < len; k++)
      send_char(k == len - 1 ? op : 1'($urandom_range(0, 1)), c[k], k == len - 1,
                k == len - 1 ? hid : 16'($urandom));
  endtask

  task automatic send_pool(int p, logic op, logic [15:0] hid);
    logic [7:0] c [] = new[pool_len[p]];
    for (int k = 0; k < pool_len[p]; k++) c[k] = pool_chars[p][k];
    send_name(op, pool_len[p], c, hid);
  endtask

  task automatic send_fill(int len, logic [7:0] ch, logic op, logic [15:0] hid);
    logic [7:0] c [] = new[len];
    foreach (c[k]) c[k] = ch;
    send_name(op, len, c, hid);
  endtask

  // Drain responses, let the pipeline settle, then write the size.
  task automatic set_size(logic [SIZE_W-1:0] sz);
    req.valid <= 0;
    @(posedge clk);
    while (rsp_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= sz;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    int sizes [8] = '{61, 1, 2, 0, 127, 5, 64, 13};
    foreach (pool_len[p]) begin
      pool_len[p] = (p % 8 == 0) ? $urandom_range(1, 18) : $urandom_range(1, 6);
      for (int k = 0; k < MAX_NAME_LEN + 2; k++) pool_chars[p][k] = 8'($urandom);
    end
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: byte extremes, both ops, every error status.
    send_fill(1, 8'h01, OP_INSERT, 16'hFFFF);
    send_fill(1, 8'h01, OP_INSERT, 16'h0001);
    send_fill(1, 8'h01, OP_LOOKUP, 16'h0000);
    send_fill(16, 8'hFF, OP_INSERT, 16'h8000);
    send_fill(16, 8'hFF, OP_LOOKUP, 16'h0000);
    send_fill(17, 8'h80, OP_INSERT, 16'h0007);
    send_fill(17, 8'h7F, OP_LOOKUP, 16'h0000);
    send_fill(3, 8'h00, OP_INSERT, 16'h0000);
    send_fill(3, 8'h00, OP_INSERT, 16'h1234);
    send_fill(2, 8'hAA, OP_LOOKUP, 16'h0000);
    send_fill(2, 8'h55, OP_INSERT, 16'h5555);
    set_size(SIZE_W'(1));
    send_fill(4, 8'h11, OP_INSERT, 16'h0011);
    send_fill(4, 8'h22, OP_INSERT, 16'h0022);
    send_fill(4, 8'h22, OP_LOOKUP, 16'h0000);
    send_fill(4, 8'h11, OP_LOOKUP, 16'h0000);

    // Random: pool names mostly, random bytes sometimes.
    for (int phase = 0; phase < 8; phase++) begin
      set_size(SIZE_W'(sizes[phase]));
      if (phase == 7) calm = 1;
      for (int n = 0; n < 30; n++) begin
        if ($urandom_range(0, 3) == 0)
          send_fill($urandom_range(1, 18), 8'($urandom), 1'($urandom_range(0, 1)),
                    16'($urandom_range(0, 3) == 0 ? 0 : $urandom));
        else
          send_pool($urandom_range(0, 31), 1'($urandom_range(0, 1)),
                    16'($urandom_range(0, 9) == 0 ? 0 : $urandom));
      end
    end

    req.valid <= 0;
    @(posedge clk);
    while (rsp_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d character requests and %0d responses over 8 table size settings",
             req_total, rsp_total);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
